// ----- design/idpa_pkg.sv -----
// Shared types and constants of the ID pool allocator.
// No dependencies; read first by every other design file.
package idpa_pkg;

    localparam int ID_W    = 8;
    localparam int LIMIT_W = 9;

    // Pool size; ID_W and LIMIT_W are sized for exactly this many IDs.
    localparam int MAX_IDS = 256;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_REJECTED  = 2'd2
    } t_status;

    typedef enum logic {
        ACT_ALLOC   = 1'b0,
        ACT_RELEASE = 1'b1
    } t_action;

    // Shift control for the free stack chain.
    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctl;

    localparam logic [LIMIT_W-1:0] LIMIT_RST  = 9'd256;
    localparam logic [LIMIT_W-1:0] RECENT_RST = 9'h1FF;

endpackage

// ----- design/idpa_req_if.sv -----
// Request channel of the ID pool allocator: action and ID being returned.
// Depends on idpa_pkg.
interface idpa_req_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [idpa_pkg::ID_W-1:0]  release_id;

    modport source (output valid, output action, output release_id, input ready);
    modport sink   (input valid, input action, input release_id, output ready);
endinterface

// ----- design/idpa_rsp_if.sv -----
// Response channel of the ID pool allocator: issued ID, last issued ID, status.
// Depends on idpa_pkg.
interface idpa_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [idpa_pkg::ID_W-1:0]           issued_id;
    logic signed [idpa_pkg::LIMIT_W-1:0] last_issued;
    logic [1:0]                          status;

    modport source (output valid, output issued_id, output last_issued, output status,
                    input ready);
    modport sink   (input valid, input issued_id, input last_issued, input status,
                    output ready);
endinterface

// ----- design/idpa_cfg_if.sv -----
// Configuration write channel of the ID pool allocator (pool_cap register).
// Depends on idpa_pkg.
interface idpa_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [idpa_pkg::LIMIT_W-1:0] pool_cap;

    modport source (output valid, output pool_cap, input ready);
    modport sink   (input valid, input pool_cap, output ready);
endinterface

// ----- design/idpa_cell.sv -----
// One entry of the free stack chain: takes its upper neighbor on push,
// its lower neighbor on pop. Depends on idpa_pkg.
module idpa_cell (
    input  logic                       i_clk,
    input  idpa_pkg::t_stk_ctl         i_ctl,
    input  logic [idpa_pkg::ID_W-1:0]  i_from_up,
    input  logic [idpa_pkg::ID_W-1:0]  i_from_down,
    output logic [idpa_pkg::ID_W-1:0]  o_val
);
    logic [idpa_pkg::ID_W-1:0] r_val;
    logic [idpa_pkg::ID_W-1:0] n_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.push) begin
            n_val = i_from_up;
        end else if (i_ctl.pop) begin
            n_val = i_from_down;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
endmodule

// ----- design/idpa_stack.sv -----
// LIFO free stack built as a row of idpa_cell; cell 0 is the top.
// Depends on idpa_pkg and idpa_cell.
module idpa_stack #(
    parameter int DEPTH = 256
) (
    input  logic                       i_clk,
    input  idpa_pkg::t_stk_ctl         i_ctl,
    input  logic [idpa_pkg::ID_W-1:0]  i_push_id,
    output logic [idpa_pkg::ID_W-1:0]  o_top
);
    logic [idpa_pkg::ID_W-1:0] w_val [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [idpa_pkg::ID_W-1:0] w_up;
        logic [idpa_pkg::ID_W-1:0] w_down;

        if (g == 0) begin : g_head
            assign w_up = i_push_id;
        end else begin : g_body
            assign w_up = w_val[g-1];
        end

        // bottom cell pops in its own value; it lies above the count then
        if (g == DEPTH - 1) begin : g_tail
            assign w_down = w_val[g];
        end else begin : g_inner
            assign w_down = w_val[g+1];
        end

        idpa_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .o_val       (w_val[g])
        );
    end

    assign o_top = w_val[0];
endmodule

// ----- design/id_pool_allocator.sv -----
// ID pool allocator: free-ID LIFO as a shifting cell chain plus a bump counter.
// Accepted requests load their responses into the output register; each shifts
// the chain at most once. Throughput: 1 request per cycle unless a held response waits.
// Reset (synchronous, active low): counter and stack count to zero, last issued to -1,
// pool_cap to 256. Stack cells are not cleared; only entries below the count are read.
module id_pool_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    idpa_cfg_if.sink    i_cfg,
    idpa_req_if.sink    i_req,
    idpa_rsp_if.source  o_rsp
);
    localparam int CNT_W   = $clog2(idpa_pkg::MAX_IDS + 1);
    localparam int LIM_CAP = (idpa_pkg::MAX_IDS > 511) ? 511 : idpa_pkg::MAX_IDS;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(idpa_pkg::MAX_IDS);
    localparam logic [idpa_pkg::LIMIT_W-1:0] LIM_MAX = idpa_pkg::LIMIT_W'(LIM_CAP);

    logic [idpa_pkg::LIMIT_W-1:0] r_limit;
    logic [idpa_pkg::LIMIT_W-1:0] r_next_fresh, n_next_fresh;
    logic [CNT_W-1:0]             r_free_count, n_free_count;
    logic [idpa_pkg::LIMIT_W-1:0] r_recent, n_recent;

    logic                         r_out_valid;
    logic [idpa_pkg::ID_W-1:0]    r_issued, n_issued;
    logic [idpa_pkg::LIMIT_W-1:0] r_last;
    idpa_pkg::t_status            r_status, n_status;

    logic                         w_accept;
    logic [idpa_pkg::LIMIT_W-1:0] w_eff_limit;
    logic [idpa_pkg::LIMIT_W-1:0] w_rel_id;
    logic [idpa_pkg::ID_W-1:0]    w_top;
    idpa_pkg::t_stk_ctl           w_ctl;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_eff_limit = (r_limit > LIM_MAX) ? LIM_MAX : r_limit;
    assign w_rel_id    = {1'b0, i_req.release_id};

    always_comb begin
        n_next_fresh = r_next_fresh;
        n_free_count = r_free_count;
        n_recent     = r_recent;
        n_issued     = '0;
        n_status     = idpa_pkg::ST_OK;
        w_ctl        = '0;
        if (i_req.action == idpa_pkg::ACT_ALLOC) begin
            if (r_free_count != '0) begin
                w_ctl.pop    = w_accept;
                n_free_count = r_free_count - CNT_W'(1);
                n_issued     = w_top;
                n_recent     = {1'b0, w_top};
            end else if (r_next_fresh < w_eff_limit) begin
                n_issued     = r_next_fresh[idpa_pkg::ID_W-1:0];
                n_next_fresh = r_next_fresh + 9'd1;
                n_recent     = r_next_fresh;
            end else begin
                n_status = idpa_pkg::ST_EXHAUSTED;
            end
        end else begin
            if (w_rel_id >= r_next_fresh) begin
                n_status = idpa_pkg::ST_REJECTED;
            end else if (w_rel_id == r_next_fresh - 9'd1) begin
                n_next_fresh = r_next_fresh - 9'd1;
            end else if (r_free_count == CNT_FULL) begin
                n_status = idpa_pkg::ST_REJECTED;
            end else begin
                w_ctl.push   = w_accept;
                n_free_count = r_free_count + CNT_W'(1);
            end
        end
    end

    idpa_stack #(
        .DEPTH (idpa_pkg::MAX_IDS)
    ) u_stack (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_push_id (i_req.release_id),
        .o_top     (w_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit      <= idpa_pkg::LIMIT_RST;
            r_next_fresh <= '0;
            r_free_count <= '0;
            r_recent     <= idpa_pkg::RECENT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_limit <= i_cfg.pool_cap;
            end
            if (w_accept) begin
                r_next_fresh <= n_next_fresh;
                r_free_count <= n_free_count;
                r_recent     <= n_recent;
                r_out_valid  <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // response payload: loaded with each accepted request
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_issued <= n_issued;
            r_last   <= n_recent;
            r_status <= n_status;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.issued_id   = r_issued;
    assign o_rsp.last_issued = r_last;
    assign o_rsp.status      = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= CNT_FULL)
        else $error("free stack count above depth");

    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.push && w_ctl.pop))
        else $error("stack push and pop in one cycle");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.pop |=> r_free_count == $past(r_free_count) - CNT_W'(1))
        else $error("pop did not lower the stack count");

    a_exhausted_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_status == idpa_pkg::ST_EXHAUSTED)
            |=> $stable(r_next_fresh) && $stable(r_free_count) && $stable(r_recent))
        else $error("exhausted request changed allocator state");

    a_resp_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted request produced no response");
endmodule
